// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level unit of the alu block
// no dependencies; included by files that hold concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property violated");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property violated");

`endif

// ===== rtl/rvalu_pkg.sv =====
// types and constants of the rv32i alu and branch compare pipeline
// no dependencies; used by every module of the block
package rvalu_pkg;

   localparam int XLEN = 32;
   localparam int IMM_SEXT_BITS = 20;
   localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

   typedef enum logic [4:0] {
      OP_LUI   = 5'd0,
      OP_AUIPC = 5'd1,
      OP_BEQ   = 5'd2,
      OP_BGE   = 5'd3,
      OP_BGEU  = 5'd4,
      OP_BLT   = 5'd5,
      OP_BLTU  = 5'd6,
      OP_BNE   = 5'd7,
      OP_ADD   = 5'd8,
      OP_SUB   = 5'd9,
      OP_AND   = 5'd10,
      OP_OR    = 5'd11,
      OP_XOR   = 5'd12,
      OP_SLL   = 5'd13,
      OP_SRL   = 5'd14,
      OP_SRA   = 5'd15,
      OP_SLT   = 5'd16,
      OP_SLTU  = 5'd17,
      OP_ADDI  = 5'd18,
      OP_ANDI  = 5'd19,
      OP_ORI   = 5'd20,
      OP_XORI  = 5'd21,
      OP_SLLI  = 5'd22,
      OP_SRLI  = 5'd23,
      OP_SRAI  = 5'd24,
      OP_SLTI  = 5'd25,
      OP_SLTIU = 5'd26,
      OP_LINK  = 5'd27
   } opcode_type;

   typedef enum logic [3:0] {
      FN_ADD,
      FN_SUB,
      FN_AND,
      FN_OR,
      FN_XOR,
      FN_SLL,
      FN_SRL,
      FN_SRA,
      FN_SLT,
      FN_SLTU,
      FN_EQ,
      FN_NE,
      FN_GE,
      FN_GEU,
      FN_PASS
   } fn_type;

   // word leaving the decode stage
   typedef struct packed {
      fn_type          fn;
      logic [XLEN-1:0] op1;
      logic [XLEN-1:0] op2;
   } dec_word_type;

   // word leaving the execute stage: every unit's result, picked later
   typedef struct packed {
      fn_type          fn;
      logic [XLEN-1:0] sum;
      logic [XLEN-1:0] diff;
      logic [XLEN-1:0] logic_val;
      logic [XLEN-1:0] shift_val;
      logic            lt;
      logic            ltu;
      logic            eq;
   } exe_word_type;

endpackage

// ===== rtl/rvalu_decode.sv =====
// stage 1: opcode decode and operand selection
// depends on rvalu_pkg
module rvalu_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [4:0]                 in_opcode,
   input  logic [rvalu_pkg::XLEN-1:0] in_operand_a,
   input  logic [rvalu_pkg::XLEN-1:0] in_operand_b,
   input  logic [rvalu_pkg::XLEN-1:0] in_immediate,
   input  logic [rvalu_pkg::XLEN-1:0] in_pc_value,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rvalu_pkg::dec_word_type    out_word
);

   logic                    valid_ff;
   logic                    valid_in;
   rvalu_pkg::dec_word_type word_ff;
   rvalu_pkg::dec_word_type word_in;
   logic [rvalu_pkg::XLEN-1:0] imm_sext;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   assign imm_sext = {{rvalu_pkg::IMM_SEXT_BITS{in_immediate[11]}}, in_immediate[11:0]};

   always_comb begin
      valid_in    = in_ready ? in_valid : valid_ff;
      word_in.op1 = in_operand_a;
      word_in.op2 = in_immediate;
      case (in_opcode)
         rvalu_pkg::OP_LUI: begin
            word_in.fn = rvalu_pkg::FN_PASS;
         end
         rvalu_pkg::OP_AUIPC: begin
            word_in.fn  = rvalu_pkg::FN_ADD;
            word_in.op1 = in_pc_value;
         end
         rvalu_pkg::OP_BEQ: begin
            word_in.fn  = rvalu_pkg::FN_EQ;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_BGE: begin
            word_in.fn  = rvalu_pkg::FN_GE;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_BGEU: begin
            word_in.fn  = rvalu_pkg::FN_GEU;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_BLT, rvalu_pkg::OP_SLT: begin
            word_in.fn  = rvalu_pkg::FN_SLT;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_BLTU, rvalu_pkg::OP_SLTU: begin
            word_in.fn  = rvalu_pkg::FN_SLTU;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_BNE: begin
            word_in.fn  = rvalu_pkg::FN_NE;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_ADD: begin
            word_in.fn  = rvalu_pkg::FN_ADD;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_SUB: begin
            word_in.fn  = rvalu_pkg::FN_SUB;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_AND: begin
            word_in.fn  = rvalu_pkg::FN_AND;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_OR: begin
            word_in.fn  = rvalu_pkg::FN_OR;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_XOR: begin
            word_in.fn  = rvalu_pkg::FN_XOR;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_SLL: begin
            word_in.fn  = rvalu_pkg::FN_SLL;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_SRL: begin
            word_in.fn  = rvalu_pkg::FN_SRL;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_SRA: begin
            word_in.fn  = rvalu_pkg::FN_SRA;
            word_in.op2 = in_operand_b;
         end
         rvalu_pkg::OP_ADDI: begin
            // only this form uses the sign-extended low 12 bits
            word_in.fn  = rvalu_pkg::FN_ADD;
            word_in.op2 = imm_sext;
         end
         rvalu_pkg::OP_ANDI:  word_in.fn = rvalu_pkg::FN_AND;
         rvalu_pkg::OP_ORI:   word_in.fn = rvalu_pkg::FN_OR;
         rvalu_pkg::OP_XORI:  word_in.fn = rvalu_pkg::FN_XOR;
         rvalu_pkg::OP_SLLI:  word_in.fn = rvalu_pkg::FN_SLL;
         rvalu_pkg::OP_SRLI:  word_in.fn = rvalu_pkg::FN_SRL;
         rvalu_pkg::OP_SRAI:  word_in.fn = rvalu_pkg::FN_SRA;
         rvalu_pkg::OP_SLTI:  word_in.fn = rvalu_pkg::FN_SLT;
         rvalu_pkg::OP_SLTIU: word_in.fn = rvalu_pkg::FN_SLTU;
         default: begin
            // link and unused codes give pc + 4
            word_in.fn  = rvalu_pkg::FN_ADD;
            word_in.op1 = in_pc_value;
            word_in.op2 = rvalu_pkg::LINK_STEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== rtl/rvalu_execute.sv =====
// stage 2: adder, subtractor and compares, logic unit and barrel shifter
// depends on rvalu_pkg
module rvalu_execute (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rvalu_pkg::dec_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rvalu_pkg::exe_word_type out_word
);

   logic                    valid_ff;
   logic                    valid_in;
   rvalu_pkg::exe_word_type word_ff;
   rvalu_pkg::exe_word_type word_in;
   logic [4:0]              shamt;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   assign shamt = in_word.op2[4:0];

   always_comb begin
      valid_in     = in_ready ? in_valid : valid_ff;
      word_in.fn   = in_word.fn;
      word_in.sum  = in_word.op1 + in_word.op2;
      word_in.diff = in_word.op1 - in_word.op2;
      word_in.lt   = $signed(in_word.op1) < $signed(in_word.op2);
      word_in.ltu  = in_word.op1 < in_word.op2;
      word_in.eq   = in_word.op1 == in_word.op2;

      case (in_word.fn)
         rvalu_pkg::FN_AND:  word_in.logic_val = in_word.op1 & in_word.op2;
         rvalu_pkg::FN_OR:   word_in.logic_val = in_word.op1 | in_word.op2;
         rvalu_pkg::FN_XOR:  word_in.logic_val = in_word.op1 ^ in_word.op2;
         default:            word_in.logic_val = in_word.op2;
      endcase

      case (in_word.fn)
         rvalu_pkg::FN_SLL: word_in.shift_val = in_word.op1 << shamt;
         rvalu_pkg::FN_SRA: word_in.shift_val = $unsigned($signed(in_word.op1) >>> shamt);
         default:           word_in.shift_val = in_word.op1 >> shamt;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== rtl/rvalu_writeback.sv =====
// stage 3: result select into the output register
// depends on rvalu_pkg
module rvalu_writeback (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  rvalu_pkg::exe_word_type    in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rvalu_pkg::XLEN-1:0] out_result
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [rvalu_pkg::XLEN-1:0] result_ff;
   logic [rvalu_pkg::XLEN-1:0] result_in;
   logic                       flag;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      flag     = 1'b0;
      case (in_word.fn)
         rvalu_pkg::FN_SLT:  flag = in_word.lt;
         rvalu_pkg::FN_SLTU: flag = in_word.ltu;
         rvalu_pkg::FN_EQ:   flag = in_word.eq;
         rvalu_pkg::FN_NE:   flag = !in_word.eq;
         rvalu_pkg::FN_GE:   flag = !in_word.lt;
         rvalu_pkg::FN_GEU:  flag = !in_word.ltu;
         default:            flag = 1'b0;
      endcase

      case (in_word.fn)
         rvalu_pkg::FN_ADD: result_in = in_word.sum;
         rvalu_pkg::FN_SUB: result_in = in_word.diff;
         rvalu_pkg::FN_AND, rvalu_pkg::FN_OR, rvalu_pkg::FN_XOR, rvalu_pkg::FN_PASS: begin
            result_in = in_word.logic_val;
         end
         rvalu_pkg::FN_SLL, rvalu_pkg::FN_SRL, rvalu_pkg::FN_SRA: begin
            result_in = in_word.shift_val;
         end
         default: result_in = {{(rvalu_pkg::XLEN-1){1'b0}}, flag};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

endmodule

// ===== rtl/rv32i_alu_and_branch_compare_unit.sv =====
// rv32i integer alu and branch compare unit: three-stage pipeline
// request channel req_*, result channel rsp_*, one result word per request word
//
// a request word carries opcode, operand_a, operand_b, immediate and pc_value
// and is taken on a cycle where req_valid and req_ready are both high. the
// unit returns one 32-bit rsp_result per word: alu value, branch-taken flag
// (0 or 1), lui immediate, auipc sum or link address pc + 4.
// stages: decode and operand select, execute (adder, compares, logic,
// shifter), result select into the output register.
// a word accepted into the decode register moves on through the execute register
// to the output register, three register stages in all.
// throughput: one word per cycle while rsp_ready is high; each stage holds one
// word, refills in the cycle it hands it on, so up to three words are in flight.
// reset (synchronous, active high) clears every stage's valid bit; the
// unit takes a word in the first cycle after reset.
// when the receiver holds rsp_ready low, rsp_result stays put and the stall
// backs up stage by stage; req_ready falls only once all three are full.
// depends on rvalu_pkg, the decode, execute and writeback stages and assert_macros.svh
`include "assert_macros.svh"

module rv32i_alu_and_branch_compare_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_immediate,
   input  logic [31:0] req_pc_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result
);

   logic                    dec_valid;
   logic                    exe_ready;
   rvalu_pkg::dec_word_type dec_word;
   logic                    exe_valid;
   logic                    wb_ready;
   rvalu_pkg::exe_word_type exe_word;

   rvalu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_opcode    (req_opcode),
      .in_operand_a (req_operand_a),
      .in_operand_b (req_operand_b),
      .in_immediate (req_immediate),
      .in_pc_value  (req_pc_value),
      .out_valid    (dec_valid),
      .out_ready    (exe_ready),
      .out_word     (dec_word)
   );

   rvalu_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (exe_ready),
      .in_word   (dec_word),
      .out_valid (exe_valid),
      .out_ready (wb_ready),
      .out_word  (exe_word)
   );

   rvalu_writeback u_writeback (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (exe_valid),
      .in_ready   (wb_ready),
      .in_word    (exe_word),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   // an accepted word always lands in the decode stage
   `ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, dec_valid)
   // a stalled output register blocks the stage feeding it
   `ASSERT_ALWAYS(a_wb_backpressure, clock, reset, !(rsp_valid && !rsp_ready) || !wb_ready)
   // a decoded word that cannot move on is still there next cycle
   `ASSERT_NEXT(a_dec_holds, clock, reset, dec_valid && !exe_ready, dec_valid)
   // input side stalls only when every stage holds a word
   `ASSERT_ALWAYS(a_full_before_stall, clock, reset,
      req_ready || (dec_valid && exe_valid && rsp_valid))

endmodule
